>>> sv/xxtea_block_cipher_top_macros.svh
// Assertion macros shared by the XXTEA block cipher RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef XXTEA_BLOCK_CIPHER_TOP_MACROS_SVH
`define XXTEA_BLOCK_CIPHER_TOP_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define XBC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another on the next edge.
`define XBC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/xbc_pkg.sv
// Shared constants and functions of the XXTEA block cipher.
// No dependencies; used by the top level by scoped names.
package xbc_pkg;

    localparam logic [31:0] DELTA     = 32'h9E37_79B9;
    localparam int          PADDR_W   = 5;
    localparam int          ROUNDS_W  = 6;

    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD3 = 3'd4;

    // Number of full rounds, 6 + 52/n, for a block of n words, n at least 2.
    function automatic logic [ROUNDS_W-1:0] rounds_for(input logic [6:0] n);
        logic [ROUNDS_W-1:0] extra;
        case (n) inside
            7'd2:            extra = 6'd26;
            7'd3:            extra = 6'd17;
            7'd4:            extra = 6'd13;
            7'd5:            extra = 6'd10;
            7'd6:            extra = 6'd8;
            7'd7:            extra = 6'd7;
            7'd8:            extra = 6'd6;
            [7'd9:7'd10]:    extra = 6'd5;
            [7'd11:7'd13]:   extra = 6'd4;
            [7'd14:7'd17]:   extra = 6'd3;
            [7'd18:7'd26]:   extra = 6'd2;
            [7'd27:7'd52]:   extra = 6'd1;
            default:         extra = 6'd0;
        endcase
        return extra + 6'd6;
    endfunction

    // The XXTEA mixing function for one word.
    function automatic logic [31:0] mix(input logic [31:0] z, input logic [31:0] y,
                                        input logic [31:0] s, input logic [31:0] k);
        logic [31:0] a;
        logic [31:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (s ^ y) + (k ^ z);
        return a ^ b;
    endfunction

endpackage

>>> sv/xbc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module xbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/xxtea_block_cipher_top.sv
// XXTEA block cipher: stream in a block of words, encrypt or decrypt it in place, stream it out.
// Depends on xbc_pkg, xbc_ram and xxtea_block_cipher_top_macros.svh.
//
// Usage: words of a block enter on the s_axis channel, one 32-bit word per item, with
// s_axis_tlast on the final word. The key and the direction are written beforehand through
// the APB port (direction at 0x00, key words 0 to 3 at 0x04 to 0x10) while the block is idle.
// After the last word the block runs 6 + 52/n passes over the n stored words, one word update
// per cycle, bounded by the single read port of the word memory. The words then leave on
// m_axis in their original order, one per cycle while the receiver is ready, m_axis_tlast
// on the final word and m_axis_tuser low. A one-word block is returned unchanged. A block
// longer than MAX_WORDS is dropped and gives a single item with tdata zero, tlast high and
// tuser high. s_axis_tready is low while a block is processed or a read word waits for the
// output register. A stalled receiver holds the output register; the next block may be
// loaded once the last word has been read out. Reset clears the key, the direction and the
// control state; the word memory needs no clearing.
`include "xxtea_block_cipher_top_macros.svh"

module xxtea_block_cipher_top #(
    parameter int MAX_WORDS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // [31:0] in_word
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // [31:0] out_word
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser,  // [0] block_error
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xbc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MAX_WORDS);
    localparam int CW = $clog2(MAX_WORDS + 1);

    typedef enum logic [1:0] {S_LOAD, S_RUN, S_EMIT, S_ERR} t_state;

    t_state      r_state;
    logic        r_dir;
    logic [31:0] r_key [4];

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [31:0]   r_first;
    logic [AW-1:0] r_lastidx;

    logic          r_iss;
    logic [AW-1:0] r_ip;
    logic [xbc_pkg::ROUNDS_W-1:0] r_ileft;
    logic [31:0]   r_isum;

    logic          r_cv;
    logic          r_cend;
    logic [AW-1:0] r_cp;
    logic [31:0]   r_csum;
    logic [31:0]   r_link;
    logic [31:0]   r_cur;
    logic          r_fwd;
    logic [31:0]   r_fwd_data;

    logic [AW-1:0] r_eidx;
    logic          r_pend;
    logic          r_pend_last;

    logic          r_ovalid;
    logic [31:0]   r_odata;
    logic          r_olast;
    logic          r_oerr;

    logic          in_acc;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic          store_ok;
    logic          wrap;
    logic [AW-1:0] iss_addr;
    logic [AW-1:0] n_ip;
    logic [31:0]   rd_word;
    logic [31:0]   z_word;
    logic [31:0]   y_word;
    logic [31:0]   mix_word;
    logic [31:0]   new_word;
    logic          load_out;
    logic          e_issue;
    logic          err_load;
    logic [xbc_pkg::ROUNDS_W-1:0] rounds;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    assign s_axis_tready = (r_state == S_LOAD) && !r_pend;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign store_ok      = !r_ovf && (r_count != CW'(MAX_WORDS));
    assign rounds        = xbc_pkg::rounds_for(7'(r_count + CW'(1)));

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        case (cfg_idx)
            xbc_pkg::REG_DIRECTION: prdata = {31'd0, r_dir};
            xbc_pkg::REG_KEY_WORD0: prdata = r_key[0];
            xbc_pkg::REG_KEY_WORD1: prdata = r_key[1];
            xbc_pkg::REG_KEY_WORD2: prdata = r_key[2];
            xbc_pkg::REG_KEY_WORD3: prdata = r_key[3];
            default:                prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_dir) begin
            wrap     = (r_ip == '0);
            iss_addr = wrap ? r_lastidx : r_ip - AW'(1);
            n_ip     = iss_addr;
        end else begin
            wrap     = (r_ip == r_lastidx);
            iss_addr = wrap ? '0 : r_ip + AW'(1);
            n_ip     = iss_addr;
        end
    end

    assign rd_word  = r_fwd ? r_fwd_data : ram_rdata;
    assign z_word   = r_dir ? rd_word : r_link;
    assign y_word   = r_dir ? r_link : rd_word;
    assign mix_word = xbc_pkg::mix(z_word, y_word, r_csum,
                                   r_key[2'(r_cp) ^ r_csum[3:2]]);
    assign new_word = r_dir ? r_cur - mix_word : r_cur + mix_word;

    assign load_out = r_pend && (!r_ovalid || m_axis_tready);
    assign e_issue  = (r_state == S_EMIT) && (!r_pend || load_out);
    assign err_load = (r_state == S_ERR) && !r_pend && (!r_ovalid || m_axis_tready);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cp;
        ram_wdata = new_word;
        ram_re    = 1'b0;
        ram_raddr = iss_addr;
        case (r_state)
            S_LOAD: begin
                ram_we    = in_acc && store_ok;
                ram_waddr = AW'(r_count);
                ram_wdata = s_axis_tdata;
            end
            S_RUN: begin
                ram_we = r_cv;
                ram_re = r_iss;
            end
            S_EMIT: begin
                ram_re    = e_issue;
                ram_raddr = r_eidx;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    xbc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_dir    <= 1'b0;
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_iss    <= 1'b0;
            r_cv     <= 1'b0;
            r_cend   <= 1'b0;
            r_fwd    <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    xbc_pkg::REG_DIRECTION: r_dir    <= pwdata[0];
                    xbc_pkg::REG_KEY_WORD0: r_key[0] <= pwdata;
                    xbc_pkg::REG_KEY_WORD1: r_key[1] <= pwdata;
                    xbc_pkg::REG_KEY_WORD2: r_key[2] <= pwdata;
                    xbc_pkg::REG_KEY_WORD3: r_key[3] <= pwdata;
                    default: begin
                    end
                endcase
            end

            r_cv   <= r_iss;
            r_cend <= r_iss && wrap && (r_ileft == xbc_pkg::ROUNDS_W'(1));
            r_cp   <= r_ip;
            r_csum <= r_isum;
            r_fwd  <= r_iss && r_cv && (iss_addr == r_cp);
            r_fwd_data <= new_word;

            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (store_ok && r_count == '0) begin
                            r_first <= s_axis_tdata;
                        end
                        if (s_axis_tlast) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_eidx  <= '0;
                            r_lastidx <= AW'(r_count);
                            if (!store_ok) begin
                                r_state <= S_ERR;
                            end else if (r_count == '0) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_RUN;
                                r_iss   <= 1'b1;
                                r_ileft <= rounds;
                                if (r_dir) begin
                                    r_link <= r_first;
                                    r_cur  <= s_axis_tdata;
                                    r_ip   <= AW'(r_count);
                                    r_isum <= 32'({26'd0, rounds} * xbc_pkg::DELTA);
                                end else begin
                                    r_link <= s_axis_tdata;
                                    r_cur  <= r_first;
                                    r_ip   <= '0;
                                    r_isum <= xbc_pkg::DELTA;
                                end
                            end
                        end else if (store_ok) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_RUN: begin
                    if (r_iss) begin
                        r_ip <= n_ip;
                        if (wrap) begin
                            r_ileft <= r_ileft - xbc_pkg::ROUNDS_W'(1);
                            r_isum  <= r_dir ? r_isum - xbc_pkg::DELTA
                                             : r_isum + xbc_pkg::DELTA;
                            if (r_ileft == xbc_pkg::ROUNDS_W'(1)) begin
                                r_iss <= 1'b0;
                            end
                        end
                    end
                    if (r_cv) begin
                        r_link <= new_word;
                        r_cur  <= rd_word;
                        if (r_cend) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (e_issue) begin
                        r_eidx <= r_eidx + AW'(1);
                        if (r_eidx == r_lastidx) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_ERR: begin
                    if (err_load) begin
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase

            if (e_issue) begin
                r_pend      <= 1'b1;
                r_pend_last <= (r_eidx == r_lastidx);
            end else if (load_out) begin
                r_pend <= 1'b0;
            end

            if (load_out) begin
                r_ovalid <= 1'b1;
                r_odata  <= ram_rdata;
                r_olast  <= r_pend_last;
                r_oerr   <= 1'b0;
            end else if (err_load) begin
                r_ovalid <= 1'b1;
                r_odata  <= 32'd0;
                r_olast  <= 1'b1;
                r_oerr   <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oerr;

    `XBC_ASSERT(a_err_item_form, !(r_ovalid && r_oerr) || (r_odata == 32'd0 && r_olast), "error item must be zero and last")
    `XBC_ASSERT_NEXT(a_pend_held, r_pend && r_ovalid && !m_axis_tready, r_pend, "read word lost while output stalled")
    `XBC_ASSERT(a_no_load_during_run, !(r_cv || r_iss) || (r_state == S_RUN), "cipher pass outside run state")
    `XBC_ASSERT(a_step_in_range, !r_cv || (r_cp <= r_lastidx), "word update beyond block end")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the XXTEA block cipher top level.
// Uses xbc_pkg for the register indexes and the address width; needs only the RTL.
// Words stream in, a local cipher model predicts every output item, and a checker compares.
module tb_top;

    localparam int          BLOCK_MAX   = 64;
    localparam logic [31:0] TEA_DELTA   = 32'h9E37_79B9;
    localparam int          IDLE_PCT    = 14;
    localparam int          SETTLE      = 400;
    localparam int          STALL_LIMIT = 5000;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        err;
    } t_cipher_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [31:0]                 s_axis_tdata = '0;  // [31:0] in_word
    logic                        s_axis_tlast = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [31:0]                 m_axis_tdata;       // [31:0] out_word
    logic                        m_axis_tlast;
    logic                        m_axis_tuser;       // [0] block_error
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [xbc_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    logic                 dir_decrypt = 1'b0;
    logic [31:0]          cipher_key [4] = '{default: 32'h0};
    logic [31:0]          block_words [$];
    logic                 block_overflow = 1'b0;
    t_cipher_result       expected_words [$];
    t_cipher_result       want_item;

    bit                   tx_idle_on = 1'b1;
    bit                   rx_idle_on = 1'b1;
    int                   words_taken = 0;
    int                   blocks_done = 0;
    int                   oversize_blocks = 0;
    int                   results_checked = 0;
    int                   mismatches = 0;
    int                   stall_cycles = 0;

    xxtea_block_cipher_top #(.MAX_WORDS(BLOCK_MAX)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] tea_mix(logic [31:0] z, logic [31:0] y, logic [31:0] s,
                                            logic [31:0] k);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        rhs = (s ^ y) + (k ^ z);
        return lhs ^ rhs;
    endfunction

    function automatic void predict_block_cipher();
        logic [31:0] v [BLOCK_MAX];
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] sum;
        logic [1:0]  e;
        logic [1:0]  ksel;
        int          n;
        int          rounds;
        t_cipher_result item;
        n = block_words.size();
        for (int i = 0; i < n; i++) v[i] = block_words[i];
        if (n >= 2) begin
            rounds = 6 + 52 / n;
            if (!dir_decrypt) begin
                z = v[n-1];
                sum = '0;
                for (int r = 0; r < rounds; r++) begin
                    sum = sum + TEA_DELTA;
                    e = sum[3:2];
                    for (int p = 0; p < n; p++) begin
                        y = (p == n - 1) ? v[0] : v[p+1];
                        ksel = p[1:0] ^ e;
                        v[p] = v[p] + tea_mix(z, y, sum, cipher_key[ksel]);
                        z = v[p];
                    end
                end
            end else begin
                y = v[0];
                sum = TEA_DELTA * rounds;
                for (int r = 0; r < rounds; r++) begin
                    e = sum[3:2];
                    for (int p = n - 1; p >= 0; p--) begin
                        z = (p == 0) ? v[n-1] : v[p-1];
                        ksel = p[1:0] ^ e;
                        v[p] = v[p] - tea_mix(z, y, sum, cipher_key[ksel]);
                        y = v[p];
                    end
                    sum = sum - TEA_DELTA;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            item.word = v[i];
            item.last = (i == n - 1);
            item.err  = 1'b0;
            expected_words.push_back(item);
        end
    endfunction

    function automatic void absorb_input_word(logic [31:0] word, logic last);
        t_cipher_result item;
        words_taken++;
        if (!block_overflow) begin
            if (block_words.size() < BLOCK_MAX) block_words.push_back(word);
            else block_overflow = 1'b1;
        end
        if (last) begin
            blocks_done++;
            if (block_overflow) begin
                oversize_blocks++;
                item.word = '0;
                item.last = 1'b1;
                item.err  = 1'b1;
                expected_words.push_back(item);
            end else begin
                predict_block_cipher();
            end
            block_words.delete();
            block_overflow = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            absorb_input_word(s_axis_tdata, s_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item: expected none, actual data %08h last %0b error %0b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want_item = expected_words.pop_front();
                if (m_axis_tdata !== want_item.word) begin
                    mismatches++;
                    $display("%0t: out_word expected %08h actual %08h",
                             $time, want_item.word, m_axis_tdata);
                end
                if (m_axis_tlast !== want_item.last) begin
                    mismatches++;
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want_item.last, m_axis_tlast);
                end
                if (m_axis_tuser !== want_item.err) begin
                    mismatches++;
                    $display("%0t: block_error expected %0b actual %0b",
                             $time, want_item.err, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !rx_idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            xbc_pkg::REG_DIRECTION: dir_decrypt = value[0];
            xbc_pkg::REG_KEY_WORD0: cipher_key[0] = value;
            xbc_pkg::REG_KEY_WORD1: cipher_key[1] = value;
            xbc_pkg::REG_KEY_WORD2: cipher_key[2] = value;
            xbc_pkg::REG_KEY_WORD3: cipher_key[3] = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic decrypt, input logic [31:0] k0, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [31:0] k3);
        apb_write(xbc_pkg::REG_DIRECTION, {31'd0, decrypt});
        apb_write(xbc_pkg::REG_KEY_WORD0, k0);
        apb_write(xbc_pkg::REG_KEY_WORD1, k1);
        apb_write(xbc_pkg::REG_KEY_WORD2, k2);
        apb_write(xbc_pkg::REG_KEY_WORD3, k3);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    // The block must be fully idle before its registers are touched.
    task automatic wait_idle();
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [31:0] word, input logic last);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_pattern(input int len, input logic [31:0] even_word,
                                input logic [31:0] odd_word);
        for (int i = 0; i < len; i++)
            send_word(i[0] ? odd_word : even_word, i == len - 1);
    endtask

    task automatic send_random_block(input int len);
        for (int i = 0; i < len; i++)
            send_word($urandom(), i == len - 1);
    endtask

    task automatic test_extreme_values();
        set_config(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pattern(1, 32'h0, 32'h0);
        send_pattern(1, 32'hFFFF_FFFF, 32'h0);
        send_pattern(2, 32'h0, 32'h0);
        send_pattern(2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();
        set_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pattern(1, 32'hFFFF_FFFF, 32'h0);
        send_pattern(2, 32'h0, 32'hFFFF_FFFF);
        send_pattern(3, 32'hFFFF_FFFF, 32'h0);
        wait_idle();
        set_config(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pattern(2, 32'hFFFF_FFFF, 32'h0);
        wait_idle();
        set_config(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
        send_pattern(4, 32'h0, 32'h0);
    endtask

    task automatic test_size_limits();
        wait_idle();
        set_config(1'b0, $urandom(), $urandom(), $urandom(), $urandom());
        send_random_block(BLOCK_MAX);
        wait_idle();
        set_config(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
        send_random_block(BLOCK_MAX + 2);
    endtask

    task automatic test_random_blocks();
        int  words;
        int  len;
        int  pick;
        bit  paused;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            set_config(phase[0], $urandom(), $urandom(), $urandom(), $urandom());
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            words  = 0;
            paused = 1'b0;
            while (words < 12) begin
                pick = $urandom_range(99);
                if (pick < 70)      len = $urandom_range(6, 1);
                else if (pick < 95) len = $urandom_range(20, 7);
                else                len = $urandom_range(40, 21);
                send_random_block(len);
                words += len;
                if (phase == 1 && !paused && words >= 6) begin
                    wait_results_drained();
                    paused = 1'b1;
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extreme_values();
        test_size_limits();
        test_random_blocks();
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Streamed %0d words in %0d blocks (%0d oversize), keys at both extremes,",
                 words_taken, blocks_done, oversize_blocks);
        $display("encrypting and decrypting; %0d output items checked.", results_checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
